// ----- hdl/rgb_kernel_convolution_defines.svh -----
// assertion macros
`ifndef RGB_KERNEL_CONVOLUTION_DEFINES_SVH
`define RGB_KERNEL_CONVOLUTION_DEFINES_SVH

// consequent must hold whenever the antecedent does, checked only while reset is released
`define RKC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`define RKC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/rkc_pkg.sv -----
package rkc_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxKernel = 5;
  localparam int unsigned NumCoef   = 25;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [2:0] {
    REG_KW     = 3'd0,
    REG_KH     = 3'd1,
    REG_IW     = 3'd2,
    REG_IH     = 3'd3,
    REG_COEF0  = 3'd4,
    REG_COEF1  = 3'd5,
    REG_COEF2  = 3'd6,
    REG_COEF3  = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_MAC   = 2'd1,
    BK_DIV   = 2'd2,
    BK_OUT   = 2'd3
  } back_state_e;

  function automatic logic [2:0] eff_kernel(input logic [2:0] k, input int unsigned mx);
    logic [2:0] r;
    r = k;
    if (r == 3'd0) r = 3'd1;
    if (32'(r) > mx) r = 3'(mx);
    if (r[0] == 1'b0) r = r - 3'd1;
    return r;
  endfunction

endpackage

// ----- hdl/rkc_pix_if.sv -----
interface rkc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       frame_start;
  modport source (output valid, red_in, green_in, blue_in, frame_start, input ready);
  modport sink (input valid, red_in, green_in, blue_in, frame_start, output ready);
endinterface

// ----- hdl/rkc_res_if.sv -----
interface rkc_res_if;
  logic        valid;
  logic        ready;
  logic [9:0]  out_col;
  logic [15:0] out_row;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic        frame_end;
  modport source (output valid, out_col, out_row, red_out, green_out, blue_out, frame_end,
                  input ready);
  modport sink (input valid, out_col, out_row, red_out, green_out, blue_out, frame_end,
                output ready);
endinterface

// ----- hdl/rkc_cfg_if.sv -----
interface rkc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/rgb_kernel_convolution.sv -----
// RGB convolution over a raster pixel stream with odd kernels up to MaxKernel square.
// The front stores each pixel in a line store and queues a job when the pixel completes a
// window; the back reads the window taps one per cycle from the single-port store read,
// then divides the three channel sums by the coefficient sum bit-serially.
// The front takes no item while a job is queued or in the back, so the store rows under
// a window stay intact. After an emitting pixel the front therefore accepts nothing more
// until its result is taken; border pixels queue no job. No clearing pass follows reset.
`include "rgb_kernel_convolution_defines.svh"
module rgb_kernel_convolution #(
  parameter int unsigned MaxWidth  = rkc_pkg::MaxWidth,
  parameter int unsigned MaxKernel = rkc_pkg::MaxKernel
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rkc_cfg_if.sink   cfg,
  rkc_pix_if.sink   pix,
  rkc_res_if.source res
);

  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned RowSelW = (MaxKernel > 1) ? $clog2(MaxKernel) : 1;
  localparam int unsigned JobW = ColW + 1 + 16 + RowSelW + 1;

  logic [2:0]   kw_q, kh_q;
  logic [10:0]  iw_q;
  logic [15:0]  ih_q;
  logic [199:0] coef_q;

  logic               st_we;
  logic [RowSelW-1:0] st_row;
  logic [ColW-1:0]    st_col;
  logic [23:0]        st_data;
  logic               fj_valid, fj_ready, bj_valid, bj_ready;
  logic [ColW:0]      fj_col;
  logic [15:0]        fj_row;
  logic [RowSelW-1:0] fj_rsel;
  logic               fj_last;
  logic [JobW-1:0]    bj_data;
  logic               busy;

  assign cfg.ready = 1'b1;
  assign busy = bj_valid || !bj_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kw_q <= 3'd3; kh_q <= 3'd3; iw_q <= 11'd640; ih_q <= 16'd480; coef_q <= '0;
    end else if (cfg.valid) begin
      unique case (rkc_pkg::reg_idx_e'(cfg.index))
        rkc_pkg::REG_KW:    kw_q <= cfg.data[2:0];
        rkc_pkg::REG_KH:    kh_q <= cfg.data[2:0];
        rkc_pkg::REG_IW:    iw_q <= cfg.data[10:0];
        rkc_pkg::REG_IH:    ih_q <= cfg.data[15:0];
        rkc_pkg::REG_COEF0: coef_q[63:0] <= cfg.data;
        rkc_pkg::REG_COEF1: coef_q[127:64] <= cfg.data;
        rkc_pkg::REG_COEF2: coef_q[191:128] <= cfg.data;
        rkc_pkg::REG_COEF3: coef_q[199:192] <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  rkc_front #(.MaxWidth(MaxWidth), .MaxKernel(MaxKernel)) u_front (
    .clk_i, .rst_ni, .pix,
    .kw_i(kw_q), .kh_i(kh_q), .iw_i(iw_q), .ih_i(ih_q), .busy_i(busy),
    .st_we_o(st_we), .st_row_o(st_row), .st_col_o(st_col), .st_data_o(st_data),
    .job_valid_o(fj_valid), .job_ready_i(fj_ready), .job_col_o(fj_col),
    .job_row_o(fj_row), .job_rsel_o(fj_rsel), .job_last_o(fj_last)
  );

  rkc_queue #(.DataW(JobW)) u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(fj_valid), .in_ready_o(fj_ready),
    .in_data_i({fj_col, fj_row, fj_rsel, fj_last}),
    .out_valid_o(bj_valid), .out_ready_i(bj_ready), .out_data_o(bj_data)
  );

  rkc_back #(.MaxWidth(MaxWidth), .MaxKernel(MaxKernel)) u_back (
    .clk_i, .rst_ni,
    .st_we_i(st_we), .st_row_i(st_row), .st_col_i(st_col), .st_data_i(st_data),
    .kw_i(kw_q), .kh_i(kh_q), .coef_i(coef_q),
    .job_valid_i(bj_valid), .job_ready_o(bj_ready),
    .job_col_i(bj_data[JobW-1 -: ColW+1]),
    .job_row_i(bj_data[RowSelW+16:RowSelW+1]),
    .job_rsel_i(bj_data[RowSelW:1]),
    .job_last_i(bj_data[0]),
    .res
  );

  `RKC_ASSERT_IMPL(a_cfg_ready, clk_i, rst_ni, 1'b1, cfg.ready, "config not ready")
  `RKC_ASSERT_IMPL(a_kw_odd, clk_i, rst_ni, 1'b1, rkc_pkg::eff_kernel(kw_q, MaxKernel) != 3'd0, "bad kernel")
  `RKC_ASSERT_NEXT(a_cfg_kw, clk_i, rst_ni, cfg.valid && cfg.index == rkc_pkg::REG_KW, kw_q == $past(cfg.data[2:0]), "kw write lost")

endmodule

// ----- hdl/rkc_front.sv -----
// stores pixels, tracks position, decides which items produce a window job
module rkc_front #(
  parameter int unsigned MaxWidth  = rkc_pkg::MaxWidth,
  parameter int unsigned MaxKernel = rkc_pkg::MaxKernel,
  localparam int unsigned ColW = $clog2(MaxWidth),
  localparam int unsigned RowSelW = (MaxKernel > 1) ? $clog2(MaxKernel) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  rkc_pix_if.sink            pix,
  input  logic [2:0]         kw_i,
  input  logic [2:0]         kh_i,
  input  logic [10:0]        iw_i,
  input  logic [15:0]        ih_i,
  // window job still queued or in the back
  input  logic               busy_i,
  // store write port
  output logic               st_we_o,
  output logic [RowSelW-1:0] st_row_o,
  output logic [ColW-1:0]    st_col_o,
  output logic [23:0]        st_data_o,
  // job out
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output logic [ColW:0]      job_col_o,
  output logic [15:0]        job_row_o,
  output logic [RowSelW-1:0] job_rsel_o,
  output logic               job_last_o
);

  logic [ColW:0]      col_q, col_d;
  logic [15:0]        row_q, row_d;
  logic [RowSelW-1:0] rsel_q, rsel_d;
  logic [ColW:0]      w;
  logic [ColW:0]      c0;
  logic [15:0]        r0;
  logic [RowSelW-1:0] rs0;
  logic [2:0]         kw, kh, hw, hh;
  logic               acc, live, emit;

  always_comb begin
    kw = rkc_pkg::eff_kernel(kw_i, MaxKernel);
    kh = rkc_pkg::eff_kernel(kh_i, MaxKernel);
    hw = (kw - 3'd1) >> 1;
    hh = (kh - 3'd1) >> 1;
    if (iw_i == 11'd0) w = (ColW+1)'(1);
    else if (32'(iw_i) > MaxWidth) w = (ColW+1)'(MaxWidth);
    else w = (ColW+1)'(iw_i);
    c0  = pix.frame_start ? '0 : col_q;
    r0  = pix.frame_start ? '0 : row_q;
    rs0 = pix.frame_start ? '0 : rsel_q;
    if (c0 >= w) c0 = w - (ColW+1)'(1);
    live = r0 < ih_i;
    emit = live && (c0 >= (ColW+1)'({hw, 1'b0})) && (r0 >= 16'({hh, 1'b0}));
    // hold the store still while a window is being read
    pix.ready = !busy_i && (!emit || job_ready_i);
    acc = pix.valid && pix.ready;
    col_d = col_q; row_d = row_q; rsel_d = rsel_q;
    if (acc) begin
      col_d = c0; row_d = r0; rsel_d = rs0;
      if (live) begin
        if (c0 + (ColW+1)'(1) >= w) begin
          col_d = '0;
          row_d = r0 + 16'd1;
          rsel_d = (32'(rs0) == MaxKernel - 1) ? '0 : rs0 + RowSelW'(1);
        end else begin
          col_d = c0 + (ColW+1)'(1);
        end
      end
    end
  end

  assign st_we_o     = acc && live;
  assign st_row_o    = rs0;
  assign st_col_o    = c0[ColW-1:0];
  assign st_data_o   = {pix.blue_in, pix.green_in, pix.red_in};
  assign job_valid_o = pix.valid && emit && !busy_i;
  assign job_col_o   = c0;
  assign job_row_o   = r0;
  assign job_rsel_o  = rs0;
  assign job_last_o  = (c0 == w - (ColW+1)'(1)) && (r0 == ih_i - 16'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; row_q <= '0; rsel_q <= '0;
    end else begin
      col_q <= col_d; row_q <= row_d; rsel_q <= rsel_d;
    end
  end

endmodule

// ----- hdl/rkc_queue.sv -----
// small job fifo between front and back
module rkc_queue #(
  parameter int unsigned DataW = 8,
  localparam int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [DataW-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] out_data_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign in_ready_o  = cnt_q != 2'(Depth);
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- hdl/rkc_back.sv -----
// walks window taps one per cycle, then serial divide of three sums
`include "rgb_kernel_convolution_defines.svh"
module rkc_back #(
  parameter int unsigned MaxWidth  = rkc_pkg::MaxWidth,
  parameter int unsigned MaxKernel = rkc_pkg::MaxKernel,
  localparam int unsigned ColW = $clog2(MaxWidth),
  localparam int unsigned RowSelW = (MaxKernel > 1) ? $clog2(MaxKernel) : 1,
  localparam int unsigned AddrW = $clog2(MaxKernel * MaxWidth)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               st_we_i,
  input  logic [RowSelW-1:0] st_row_i,
  input  logic [ColW-1:0]    st_col_i,
  input  logic [23:0]        st_data_i,
  input  logic [2:0]         kw_i,
  input  logic [2:0]         kh_i,
  input  logic [199:0]       coef_i,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  logic [ColW:0]      job_col_i,
  input  logic [15:0]        job_row_i,
  input  logic [RowSelW-1:0] job_rsel_i,
  input  logic               job_last_i,
  rkc_res_if.source          res
);

  logic [23:0] store_q [MaxKernel * MaxWidth];
  logic [23:0] rd_q;
  logic [AddrW-1:0] raddr;

  rkc_pkg::back_state_e st_q, st_d;
  logic [ColW:0]      col_q;
  logic [15:0]        row_q;
  logic [RowSelW-1:0] rsel_q;
  logic               last_q;
  logic [2:0]         i_q, j_q;
  logic [4:0]         n_q;
  logic               rdv_q;
  logic [7:0]         kd_q;
  logic [31:0]        acc_q [3];
  logic [31:0]        div_q;
  logic [31:0]        rem_q [3];
  logic [5:0]         bit_q;
  logic [7:0]         q_q [3];
  logic [2:0]         kw, kh, hw, hh;
  logic               last_tap;
  logic [31:0]        rt;
  logic [RowSelW-1:0] r;
  logic [ColW-1:0]    c;
  logic [31:0]        dv;
  logic [32:0]        trial [3];

  always_comb begin
    kw = rkc_pkg::eff_kernel(kw_i, MaxKernel);
    kh = rkc_pkg::eff_kernel(kh_i, MaxKernel);
    hw = (kw - 3'd1) >> 1;
    hh = (kh - 3'd1) >> 1;
    // oldest window row is kh-1 rows behind the current row in the ring
    rt = 32'(rsel_q) + 32'(j_q) + MaxKernel + 1 - 32'(kh);
    if (rt >= MaxKernel) rt = rt - MaxKernel;
    if (rt >= MaxKernel) rt = rt - MaxKernel;
    r = RowSelW'(rt);
    c = ColW'(col_q - (ColW+1)'({hw, 1'b0}) + (ColW+1)'(i_q));
    raddr = AddrW'(32'(r) * MaxWidth + 32'(c));
    last_tap = (i_q == kw - 3'd1) && (j_q == kh - 3'd1);
    dv = (div_q == 32'd0) ? 32'd1 : div_q;
    for (int k = 0; k < 3; k++) begin
      trial[k] = {rem_q[k], acc_q[k][31]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we_i) store_q[AddrW'(32'(st_row_i) * MaxWidth + 32'(st_col_i))] <= st_data_i;
    rd_q <= store_q[raddr];
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      rkc_pkg::BK_IDLE: if (job_valid_i) st_d = rkc_pkg::BK_MAC;
      rkc_pkg::BK_MAC:  if (kd_q == 8'h01) st_d = rkc_pkg::BK_DIV;
      rkc_pkg::BK_DIV:  if (bit_q == 6'd31) st_d = rkc_pkg::BK_OUT;
      rkc_pkg::BK_OUT:  if (res.ready) st_d = rkc_pkg::BK_IDLE;
      default:          st_d = rkc_pkg::BK_IDLE;
    endcase
  end

  assign job_ready_o   = st_q == rkc_pkg::BK_IDLE;
  assign res.valid     = st_q == rkc_pkg::BK_OUT;
  assign res.out_col   = 10'(col_q - (ColW+1)'(hw));
  assign res.out_row   = row_q - 16'(hh);
  assign res.red_out   = q_q[0];
  assign res.green_out = q_q[1];
  assign res.blue_out  = q_q[2];
  assign res.frame_end = last_q;

  always_ff @(posedge clk_i) begin
    if (st_q == rkc_pkg::BK_IDLE && job_valid_i) begin
      col_q <= job_col_i; row_q <= job_row_i; rsel_q <= job_rsel_i; last_q <= job_last_i;
      for (int k = 0; k < 3; k++) acc_q[k] <= '0;
      div_q <= '0;
    end else if (st_q == rkc_pkg::BK_MAC) begin
      if (rdv_q) begin
        div_q <= div_q + {{24{coef_i[8*n_q+7]}}, coef_i[8*n_q +: 8]};
        for (int k = 0; k < 3; k++) begin
          acc_q[k] <= acc_q[k] + 32'(32'($signed({1'b0, rd_q[8*k +: 8]})) *
                                     32'($signed(coef_i[8*n_q +: 8])));
          rem_q[k] <= '0;
        end
      end
    end else if (st_q == rkc_pkg::BK_DIV) begin
      for (int k = 0; k < 3; k++) begin
        if (trial[k] >= {1'b0, dv}) begin
          rem_q[k] <= 32'(trial[k] - {1'b0, dv});
          q_q[k] <= {q_q[k][6:0], 1'b1};
        end else begin
          rem_q[k] <= trial[k][31:0];
          q_q[k] <= {q_q[k][6:0], 1'b0};
        end
        acc_q[k] <= {acc_q[k][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= rkc_pkg::BK_IDLE;
      i_q <= '0; j_q <= '0; n_q <= '0; rdv_q <= 1'b0; kd_q <= '0; bit_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == rkc_pkg::BK_IDLE) begin
        i_q <= '0; j_q <= '0; n_q <= '0; rdv_q <= 1'b0; kd_q <= '0; bit_q <= '0;
      end else if (st_q == rkc_pkg::BK_MAC) begin
        // rdv_q marks that rd_q holds the tap issued last cycle; kd_q flags the final one
        if (rdv_q) n_q <= n_q + 5'd1;
        if (kd_q == 8'h00) begin
          rdv_q <= 1'b1;
          if (last_tap) kd_q <= 8'h01;
          else if (i_q == kw - 3'd1) begin
            i_q <= '0; j_q <= j_q + 3'd1;
          end else begin
            i_q <= i_q + 3'd1;
          end
        end else begin
          kd_q <= 8'hff;
        end
      end else if (st_q == rkc_pkg::BK_DIV) begin
        bit_q <= bit_q + 6'd1;
      end
    end
  end

  `RKC_ASSERT_IMPL(a_idle_no_out, clk_i, rst_ni, st_q == rkc_pkg::BK_IDLE, !res.valid, "out while idle")
  `RKC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, res.valid && !res.ready, res.valid && $stable(q_q[0]), "result dropped")
  `RKC_ASSERT_IMPL(a_tap_range, clk_i, rst_ni, st_q == rkc_pkg::BK_MAC, n_q < 5'd26, "tap index out of range")

endmodule
